// ===== rtl/ffra_pkg.sv =====
// Shared types, codes and helpers for the frame-fenced ring allocator.
// Depends on nothing; every other file of the block but ffra_divider uses it.
package ffra_pkg;

   // Function codes of an input item.
   localparam logic [2:0] FUNC_BEGIN  = 3'd0;
   localparam logic [2:0] FUNC_ALLOC  = 3'd1;
   localparam logic [2:0] FUNC_END    = 3'd2;
   localparam logic [2:0] FUNC_ABORT  = 3'd3;
   localparam logic [2:0] FUNC_RETIRE = 3'd4;

   // Status codes of a result item.
   localparam logic [3:0] ST_OK       = 4'd0;
   localparam logic [3:0] ST_NOT_INIT = 4'd1;
   localparam logic [3:0] ST_INVALID  = 4'd2;
   localparam logic [3:0] ST_ACTIVE   = 4'd3;
   localparam logic [3:0] ST_NO_FRAME = 4'd4;
   localparam logic [3:0] ST_RANGE    = 4'd5;
   localparam logic [3:0] ST_ORDER    = 4'd6;
   localparam logic [3:0] ST_OVERFLOW = 4'd7;
   localparam logic [3:0] ST_NO_SPACE = 4'd8;

   // Configuration register indexes.
   localparam logic [1:0] REG_ENABLE   = 2'd0;
   localparam logic [1:0] REG_CAPACITY = 2'd1;
   localparam logic [1:0] REG_FRAMES   = 2'd2;

   localparam logic [31:0] CAPACITY_RESET = 32'd65536;
   localparam logic [3:0]  FRAMES_RESET   = 4'd3;

   // State update applied by the datapath when an item finishes.
   localparam logic [2:0] C_NONE   = 3'd0;
   localparam logic [2:0] C_STAT   = 3'd1;
   localparam logic [2:0] C_FAIL   = 3'd2;
   localparam logic [2:0] C_BEGIN  = 3'd3;
   localparam logic [2:0] C_ALLOC  = 3'd4;
   localparam logic [2:0] C_END    = 3'd5;
   localparam logic [2:0] C_ABORT  = 3'd6;
   localparam logic [2:0] C_RETIRE = 3'd7;

   // Slot table read address select.
   localparam logic [1:0] RD_ACTIVE = 2'd0;
   localparam logic [1:0] RD_SLOT   = 2'd1;
   localparam logic [1:0] RD_SCAN   = 2'd2;

   // Remainder unit operations.
   localparam logic DIV_HEAD_MOD_CAP  = 1'b0;
   localparam logic DIV_PHYS_MOD_ALGN = 1'b1;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  frame_slot;
      logic        waited;
      logic [31:0] request_size;
      logic [31:0] align_bytes;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] slice_offset;
      logic [63:0] slice_virtual;
      logic [2:0]  slice_frame;
      logic [31:0] slice_generation;
      logic [31:0] used_bytes;
      logic [31:0] free_bytes;
      logic [3:0]  in_flight_frames;
      logic        frame_open;
      logic [31:0] wraps_total;
      logic [31:0] stalls_total;
      logic [31:0] failures_total;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic [1:0] rd_sel;
      logic       ref_latch;
      logic       scan_inc;
      logic       div_start;
      logic       div_mode;
      logic       phys_latch;
      logic       calc_latch;
      logic [2:0] commit;
      logic [3:0] status;
      logic       fin;
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       ring_ready;
      logic       frame_active;
      logic       slot_in_range;
      logic       slot_in_flight;
      logic       arg_zero;
      logic       size_over_cap;
      logic       div_done;
      logic       scan_older;
      logic       scan_last;
      logic       align_overflow;
      logic       head_overflow;
      logic       no_space;
   } stat_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] value);
      sat_inc = (value == 32'hFFFF_FFFF) ? value : value + 32'd1;
   endfunction

endpackage

// ===== rtl/ffra_divider.sv =====
// Bit-serial remainder unit: one quotient bit per cycle.
// Depends on ffra_pkg only through the block's conventions; no package items used.
module ffra_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   input  logic [6:0]  steps,
   output logic        done,
   output logic [31:0] remainder
);

   logic [63:0] num_ff;
   logic [31:0] rem_ff;
   logic [6:0]  cnt_ff;
   logic        busy_ff;
   logic [32:0] trial;
   logic [32:0] diff;

   assign trial = {rem_ff, num_ff[63]};
   assign diff  = trial - {1'b0, divisor};
   assign done      = busy_ff && (cnt_ff == 7'd0);
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= steps;
      end else if (busy_ff) begin
         if (cnt_ff == 7'd0) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= 32'd0;
      end else if (busy_ff && (cnt_ff != 7'd0)) begin
         num_ff <= {num_ff[62:0], 1'b0};
         rem_ff <= diff[32] ? trial[31:0] : diff[31:0];
      end
   end

endmodule

// ===== rtl/ffra_datapath.sv =====
// Datapath of the ring allocator: positions, slot table, counters, result register.
// Depends on ffra_pkg and ffra_divider; driven by ffra_ctrl commands.
module ffra_datapath #(
   parameter int MAX_FRAMES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  ffra_pkg::req_type   req,
   input  ffra_pkg::cmd_type   cmd,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   output ffra_pkg::stat_type  stat,
   output ffra_pkg::rsp_type   rsp,
   output logic                rsp_valid
);

   localparam int SW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

   // Configuration.
   logic        en_ff;
   logic [31:0] cap_ff;
   logic [3:0]  fc_ff;
   logic        cfg_clear;
   logic        ring_ready;

   // Ring state.
   ffra_pkg::req_type     req_ff;
   logic [63:0]           head_ff;
   logic [63:0]           tail_ff;
   logic [MAX_FRAMES-1:0] inflight_ff;
   logic [MAX_FRAMES-1:0] row_valid_ff;
   logic [SW-1:0]         active_ff;
   logic                  act_valid_ff;
   logic [31:0]           fwraps_ff;
   logic [31:0]           wraps_ff;
   logic [31:0]           stalls_ff;
   logic [31:0]           fails_ff;

   // Slot table.
   logic [63:0] start_mem  [MAX_FRAMES];
   logic [63:0] retire_mem [MAX_FRAMES];
   logic [31:0] gen_mem    [MAX_FRAMES];
   logic [63:0] rd_start_ff;
   logic [63:0] rd_retire_ff;
   logic [31:0] rd_gen_ff;
   logic [SW-1:0] rd_addr;
   logic [SW-1:0] slot_idx;
   logic [SW-1:0] idx_ff;

   // Begin and allocate work registers.
   logic [63:0] ref_retire_ff;
   logic [31:0] ref_gen_ff;
   logic [31:0] gen_in;
   logic [31:0] phys_ff;
   logic [31:0] aligned_ff;
   logic [31:0] pad_ff;
   logic [32:0] used_ff;
   logic        wrapped_ff;
   logic        align_ovf_ff;
   logic [63:0] avail_ff;

   logic [33:0] align_sum;
   logic [33:0] aligned34;
   logic [33:0] end_sum;
   logic        crosses;
   logic [31:0] pad_in;
   logic [32:0] used_in;
   logic [64:0] head_sum;
   logic [MAX_FRAMES-1:0] fc_mask;

   // Divider hookup.
   logic        div_done;
   logic [31:0] div_rem;
   logic [63:0] div_num;
   logic [31:0] div_den;
   logic [6:0]  div_steps;

   // Result registers.
   logic [3:0]  status_ff;
   logic [31:0] sl_offset_ff;
   logic [63:0] sl_virtual_ff;
   logic [2:0]  sl_frame_ff;
   logic [31:0] sl_gen_ff;
   ffra_pkg::rsp_type rsp_ff;
   logic        rsp_valid_ff;
   logic [63:0] occ64;
   logic [31:0] cap_eff;
   logic [7:0]  active8;

   assign cfg_clear = csr_we && ((csr_index == ffra_pkg::REG_ENABLE) ||
                                 (csr_index == ffra_pkg::REG_CAPACITY) ||
                                 (csr_index == ffra_pkg::REG_FRAMES));
   assign ring_ready = en_ff && (cap_ff != 32'd0) && (fc_ff != 4'd0) &&
                       (5'(fc_ff) <= 5'(MAX_FRAMES));
   assign slot_idx = req_ff.frame_slot[SW-1:0];
   assign active8  = 8'(active_ff);

   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         fc_mask[i] = (5'(i) < 5'(fc_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff  <= 1'b0;
         cap_ff <= ffra_pkg::CAPACITY_RESET;
         fc_ff  <= ffra_pkg::FRAMES_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ffra_pkg::REG_ENABLE:   en_ff  <= csr_wdata[0];
            ffra_pkg::REG_CAPACITY: cap_ff <= csr_wdata;
            ffra_pkg::REG_FRAMES:   fc_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
      end
   end

   // Remainder unit: head mod capacity, then physical offset mod alignment.
   assign div_num   = (cmd.div_mode == ffra_pkg::DIV_HEAD_MOD_CAP) ? head_ff : {phys_ff, 32'd0};
   assign div_den   = (cmd.div_mode == ffra_pkg::DIV_HEAD_MOD_CAP) ? cap_ff : req_ff.align_bytes;
   assign div_steps = (cmd.div_mode == ffra_pkg::DIV_HEAD_MOD_CAP) ? 7'd64 : 7'd32;

   ffra_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .steps     (div_steps),
      .done      (div_done),
      .remainder (div_rem)
   );

   // Slot table, read registered at one address.
   always_comb begin
      unique case (cmd.rd_sel)
         ffra_pkg::RD_SLOT: rd_addr = slot_idx;
         ffra_pkg::RD_SCAN: rd_addr = idx_ff;
         default:           rd_addr = active_ff;
      endcase
   end

   assign gen_in = (ref_gen_ff == 32'hFFFF_FFFF) ? 32'd1 : ref_gen_ff + 32'd1;

   always_ff @(posedge clock) begin
      if (cmd.commit == ffra_pkg::C_BEGIN) begin
         start_mem[slot_idx]  <= head_ff;
         retire_mem[slot_idx] <= head_ff;
         gen_mem[slot_idx]    <= gen_in;
      end else if (cmd.commit == ffra_pkg::C_END) begin
         retire_mem[active_ff] <= head_ff;
      end
      rd_start_ff  <= row_valid_ff[rd_addr] ? start_mem[rd_addr]  : 64'd0;
      rd_retire_ff <= row_valid_ff[rd_addr] ? retire_mem[rd_addr] : 64'd0;
      rd_gen_ff    <= row_valid_ff[rd_addr] ? gen_mem[rd_addr]    : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (cmd.ref_latch) begin
         ref_retire_ff <= rd_retire_ff;
         ref_gen_ff    <= rd_gen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.ref_latch) begin
         idx_ff <= '0;
      end else if (cmd.scan_inc) begin
         idx_ff <= idx_ff + SW'(1);
      end
   end

   // Alignment and wrap arithmetic.
   assign align_sum = 34'(phys_ff) + 34'(req_ff.align_bytes) - 34'(div_rem);
   assign aligned34 = (div_rem == 32'd0) ? 34'(phys_ff) : align_sum;
   assign end_sum   = 34'(aligned34[31:0]) + 34'(req_ff.request_size);
   assign crosses   = end_sum > 34'(cap_ff);
   assign pad_in    = crosses ? cap_ff - phys_ff : aligned34[31:0] - phys_ff;
   assign used_in   = 33'(pad_in) + 33'(req_ff.request_size);
   assign head_sum  = {1'b0, head_ff} + 65'(used_ff);

   always_ff @(posedge clock) begin
      if (cmd.phys_latch) begin
         phys_ff <= div_rem;
      end
      if (cmd.calc_latch) begin
         aligned_ff   <= crosses ? 32'd0 : aligned34[31:0];
         pad_ff       <= pad_in;
         used_ff      <= used_in;
         wrapped_ff   <= crosses;
         align_ovf_ff <= (aligned34[33:32] != 2'd0);
         avail_ff     <= 64'(cap_ff) - (head_ff - tail_ff);
      end
   end

   // Ring state updates.
   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         head_ff      <= 64'd0;
         tail_ff      <= 64'd0;
         inflight_ff  <= '0;
         row_valid_ff <= '0;
         active_ff    <= '0;
         act_valid_ff <= 1'b0;
         fwraps_ff    <= 32'd0;
         wraps_ff     <= 32'd0;
         stalls_ff    <= 32'd0;
         fails_ff     <= 32'd0;
      end else begin
         unique case (cmd.commit)
            ffra_pkg::C_BEGIN: begin
               if (inflight_ff[slot_idx]) begin
                  if (req_ff.waited && (ref_retire_ff > tail_ff)) begin
                     stalls_ff <= ffra_pkg::sat_inc(stalls_ff);
                  end
                  tail_ff               <= ref_retire_ff;
                  inflight_ff[slot_idx] <= 1'b0;
               end
               row_valid_ff[slot_idx] <= 1'b1;
               active_ff              <= slot_idx;
               act_valid_ff           <= 1'b1;
               fwraps_ff              <= 32'd0;
            end
            ffra_pkg::C_ALLOC: begin
               head_ff <= head_sum[63:0];
               if (wrapped_ff) begin
                  wraps_ff  <= ffra_pkg::sat_inc(wraps_ff);
                  fwraps_ff <= ffra_pkg::sat_inc(fwraps_ff);
               end
            end
            ffra_pkg::C_FAIL: begin
               fails_ff <= ffra_pkg::sat_inc(fails_ff);
            end
            ffra_pkg::C_END: begin
               inflight_ff[active_ff] <= 1'b1;
               act_valid_ff           <= 1'b0;
               fwraps_ff              <= 32'd0;
            end
            ffra_pkg::C_ABORT: begin
               head_ff <= rd_start_ff;
               if (wraps_ff != 32'hFFFF_FFFF) begin
                  wraps_ff <= (wraps_ff >= fwraps_ff) ? wraps_ff - fwraps_ff : 32'd0;
               end
               act_valid_ff <= 1'b0;
               fwraps_ff    <= 32'd0;
            end
            ffra_pkg::C_RETIRE: begin
               inflight_ff <= '0;
               tail_ff     <= head_ff;
            end
            default: ;
         endcase
      end
   end

   // Per-item result fields, set when the item finishes.
   always_ff @(posedge clock) begin
      if (cmd.commit != ffra_pkg::C_NONE) begin
         status_ff <= cmd.status;
         if (cmd.commit == ffra_pkg::C_ALLOC) begin
            sl_offset_ff  <= aligned_ff;
            sl_virtual_ff <= head_ff + 64'(pad_ff);
            sl_frame_ff   <= active8[2:0];
            sl_gen_ff     <= rd_gen_ff;
         end else begin
            sl_offset_ff  <= 32'd0;
            sl_virtual_ff <= 64'd0;
            sl_frame_ff   <= 3'd0;
            sl_gen_ff     <= 32'd0;
         end
      end
   end

   assign occ64   = head_ff - tail_ff;
   assign cap_eff = ring_ready ? cap_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         rsp_ff.status           <= status_ff;
         rsp_ff.slice_offset     <= sl_offset_ff;
         rsp_ff.slice_virtual    <= sl_virtual_ff;
         rsp_ff.slice_frame      <= sl_frame_ff;
         rsp_ff.slice_generation <= sl_gen_ff;
         rsp_ff.used_bytes       <= occ64[31:0];
         rsp_ff.free_bytes       <= cap_eff - occ64[31:0];
         rsp_ff.in_flight_frames <= ring_ready ? 4'($countones(inflight_ff & fc_mask)) : 4'd0;
         rsp_ff.frame_open       <= act_valid_ff;
         rsp_ff.wraps_total      <= wraps_ff;
         rsp_ff.stalls_total     <= stalls_ff;
         rsp_ff.failures_total   <= fails_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.fin;
      end
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // Status back to the controller.
   assign stat.func           = req_ff.func;
   assign stat.ring_ready     = ring_ready;
   assign stat.frame_active   = act_valid_ff;
   assign stat.slot_in_range  = req_ff.frame_slot < 8'(fc_ff);
   assign stat.slot_in_flight = inflight_ff[slot_idx];
   assign stat.arg_zero       = (req_ff.request_size == 32'd0) || (req_ff.align_bytes == 32'd0);
   assign stat.size_over_cap  = req_ff.request_size > cap_ff;
   assign stat.div_done       = div_done;
   assign stat.scan_older     = inflight_ff[idx_ff] && (rd_retire_ff < ref_retire_ff);
   assign stat.scan_last      = (5'(idx_ff) == (5'(fc_ff) - 5'd1));
   assign stat.align_overflow = align_ovf_ff;
   assign stat.head_overflow  = head_sum[64];
   assign stat.no_space       = 64'(used_ff) > avail_ff;

endmodule

// ===== rtl/ffra_ctrl.sv =====
// Controller state machine of the ring allocator.
// Depends on ffra_pkg; issues commands to ffra_datapath and reads its status.
module ffra_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ffra_pkg::stat_type stat,
   output ffra_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LOAD   = 4'd1;
   localparam logic [3:0] S_DISP   = 4'd2;
   localparam logic [3:0] S_B_RD   = 4'd3;
   localparam logic [3:0] S_B_LAT  = 4'd4;
   localparam logic [3:0] S_B_SRD  = 4'd5;
   localparam logic [3:0] S_B_SCMP = 4'd6;
   localparam logic [3:0] S_A_W1   = 4'd7;
   localparam logic [3:0] S_A_D2   = 4'd8;
   localparam logic [3:0] S_A_W2   = 4'd9;
   localparam logic [3:0] S_A_C2   = 4'd10;
   localparam logic [3:0] S_FIN    = 4'd11;
   localparam logic [3:0] S_B_COM  = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = ffra_pkg::RD_ACTIVE;
      state_in   = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = S_DISP;
         end
         S_DISP: begin
            state_in   = S_FIN;
            cmd.commit = ffra_pkg::C_STAT;
            cmd.status = ffra_pkg::ST_OK;
            if (stat.func > ffra_pkg::FUNC_RETIRE) begin
               cmd.status = ffra_pkg::ST_INVALID;
            end else if (!stat.ring_ready) begin
               cmd.status = ffra_pkg::ST_NOT_INIT;
               if (stat.func == ffra_pkg::FUNC_ALLOC) begin
                  cmd.commit = ffra_pkg::C_FAIL;
               end
            end else if (stat.func == ffra_pkg::FUNC_BEGIN) begin
               if (stat.frame_active) begin
                  cmd.status = ffra_pkg::ST_ACTIVE;
               end else if (!stat.slot_in_range) begin
                  cmd.status = ffra_pkg::ST_RANGE;
               end else begin
                  cmd.commit = ffra_pkg::C_NONE;
                  state_in   = S_B_RD;
               end
            end else if (stat.func == ffra_pkg::FUNC_ALLOC) begin
               cmd.commit = ffra_pkg::C_FAIL;
               if (!stat.frame_active) begin
                  cmd.status = ffra_pkg::ST_NO_FRAME;
               end else if (stat.arg_zero) begin
                  cmd.status = ffra_pkg::ST_INVALID;
               end else if (stat.size_over_cap) begin
                  cmd.status = ffra_pkg::ST_NO_SPACE;
               end else begin
                  cmd.commit    = ffra_pkg::C_NONE;
                  cmd.div_start = 1'b1;
                  cmd.div_mode  = ffra_pkg::DIV_HEAD_MOD_CAP;
                  state_in      = S_A_W1;
               end
            end else if (!stat.frame_active) begin
               if (stat.func == ffra_pkg::FUNC_RETIRE) begin
                  cmd.commit = ffra_pkg::C_RETIRE;
               end else begin
                  cmd.status = ffra_pkg::ST_NO_FRAME;
               end
            end else if (stat.func == ffra_pkg::FUNC_RETIRE) begin
               cmd.status = ffra_pkg::ST_ACTIVE;
            end else if (stat.func == ffra_pkg::FUNC_END) begin
               cmd.commit = ffra_pkg::C_END;
            end else begin
               cmd.commit = ffra_pkg::C_ABORT;
            end
         end
         S_B_RD: begin
            cmd.rd_sel = ffra_pkg::RD_SLOT;
            state_in   = S_B_LAT;
         end
         S_B_LAT: begin
            cmd.ref_latch = 1'b1;
            if (stat.slot_in_flight) begin
               state_in = S_B_SRD;
            end else begin
               state_in = S_B_COM;
            end
         end
         S_B_COM: begin
            // The slot's generation was captured on the previous edge.
            cmd.commit = ffra_pkg::C_BEGIN;
            cmd.status = ffra_pkg::ST_OK;
            state_in   = S_FIN;
         end
         S_B_SRD: begin
            cmd.rd_sel = ffra_pkg::RD_SCAN;
            state_in   = S_B_SCMP;
         end
         S_B_SCMP: begin
            if (stat.scan_older) begin
               cmd.commit = ffra_pkg::C_STAT;
               cmd.status = ffra_pkg::ST_ORDER;
               state_in   = S_FIN;
            end else if (stat.scan_last) begin
               cmd.commit = ffra_pkg::C_BEGIN;
               cmd.status = ffra_pkg::ST_OK;
               state_in   = S_FIN;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = S_B_SRD;
            end
         end
         S_A_W1: begin
            cmd.div_mode = ffra_pkg::DIV_HEAD_MOD_CAP;
            if (stat.div_done) begin
               cmd.phys_latch = 1'b1;
               state_in       = S_A_D2;
            end
         end
         S_A_D2: begin
            cmd.div_start = 1'b1;
            cmd.div_mode  = ffra_pkg::DIV_PHYS_MOD_ALGN;
            state_in      = S_A_W2;
         end
         S_A_W2: begin
            cmd.div_mode = ffra_pkg::DIV_PHYS_MOD_ALGN;
            if (stat.div_done) begin
               cmd.calc_latch = 1'b1;
               state_in       = S_A_C2;
            end
         end
         S_A_C2: begin
            state_in   = S_FIN;
            cmd.commit = ffra_pkg::C_FAIL;
            if (stat.align_overflow || stat.head_overflow) begin
               cmd.status = ffra_pkg::ST_OVERFLOW;
            end else if (stat.no_space) begin
               cmd.status = ffra_pkg::ST_NO_SPACE;
            end else begin
               cmd.commit = ffra_pkg::C_ALLOC;
               cmd.status = ffra_pkg::ST_OK;
            end
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/frame_fenced_ring_allocator.sv =====
// Top level of the frame-fenced ring allocator.
// Depends on ffra_pkg, ffra_ctrl and ffra_datapath (which holds ffra_divider).
//
//   Channel   Ports                              Transfer
//   ------    ---------------------------------  ------------------------------------
//   input     start, busy, req_data              taken at an edge with start high, busy low
//   result    rsp_valid, rsp_data                one item, shown for one cycle
//   config    csr_we, csr_index, csr_wdata       written at an edge with csr_we high
//
// One item is worked on at a time. End, abort, retire-all and every item rejected at
// dispatch pass through the load, dispatch and finish states to the result strobe; a
// begin on a slot with nothing in flight also reads, latches and commits its slot entry.
// A begin that retires an in-flight slot scans the slot table one entry at a time, with
// a read and a compare state per entry. An allocation runs two passes through the
// bit-serial remainder unit (64 steps for head modulo capacity, 32 for offset modulo
// alignment), which sets the item rate. The next item can be offered with the strobe.
// Reset is synchronous and needs no clearing pass; the slot table carries valid bits.
// The result strobe cannot be stalled; busy drops in the cycle the result is shown.
module frame_fenced_ring_allocator #(
   parameter int MAX_FRAMES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffra_pkg::req_type req_data,
   output logic              rsp_valid,
   output ffra_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   // Commands flow from the controller, status flows back.
   ffra_pkg::cmd_type  cmd;
   ffra_pkg::stat_type stat;

   ffra_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // The datapath owns all ring state, the slot table and the result register.
   ffra_datapath #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .rsp       (rsp_data),
      .rsp_valid (rsp_valid)
   );

endmodule

// ===== rtl/ffra_checker.sv =====
// Port-level checks for the frame-fenced ring allocator, bound to the top level.
// Depends on ffra_pkg and frame_fenced_ring_allocator.
module ffra_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input ffra_pkg::rsp_type rsp_data
);

   // An accepted item keeps the block busy until its result is shown.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted item");

   // The result appears exactly when busy drops.
   a_fin_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_result_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of an item");

   // Slice fields carry nothing unless the item succeeded.
   a_slice_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ffra_pkg::ST_OK)) |->
         ((rsp_data.slice_offset == 32'd0) && (rsp_data.slice_generation == 32'd0)))
      else $error("slice fields set on a failed item");

endmodule

bind frame_fenced_ring_allocator ffra_checker u_ffra_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ===== verif/frame_fenced_ring_allocator_chk.sv =====
// Result checker for the frame-fenced ring allocator: tracks accepted items and
// register writes, predicts each result item and compares it field by field.
// Depends on ffra_pkg for the item types, status, function and register codes.
module frame_fenced_ring_allocator_chk
   import ffra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          errors,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic        ring_on;
   logic [31:0] ring_cap;
   logic [3:0]  ring_frames;

   logic [63:0] head_pos, tail_pos;
   logic [63:0] slot_begin_pos [0:7];
   logic [63:0] slot_fence [0:7];
   logic [31:0] slot_gen [0:7];
   logic        slot_busy [0:7];
   logic        slot_open [0:7];
   logic [3:0]  open_slot;
   logic        open_valid;
   logic [31:0] open_wraps, wrap_cnt, stall_cnt, fail_cnt;

   rsp_type pending_rsp [$];

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic logic ring_ready();
      return ring_on && ring_cap != 0 && ring_frames >= 1 && ring_frames <= 8;
   endfunction

   function automatic void clear_ring();
      head_pos = '0;
      tail_pos = '0;
      for (int i = 0; i < 8; i++) begin
         slot_begin_pos[i] = '0;
         slot_fence[i] = '0;
         slot_gen[i] = '0;
         slot_busy[i] = 1'b0;
         slot_open[i] = 1'b0;
      end
      open_slot = '0;
      open_valid = 1'b0;
      open_wraps = '0;
      wrap_cnt = '0;
      stall_cnt = '0;
      fail_cnt = '0;
   endfunction

   function automatic logic [3:0] begin_frame(input logic [7:0] slot, input logic waited);
      if (open_valid) return ST_ACTIVE;
      if (slot >= ring_frames) return ST_RANGE;
      if (slot_busy[slot]) begin
         for (int i = 0; i < ring_frames; i++)
            if (slot_busy[i] && slot_fence[i] < slot_fence[slot]) return ST_ORDER;
         if (waited && slot_fence[slot] > tail_pos) stall_cnt = bump(stall_cnt);
         tail_pos = slot_fence[slot];
         slot_busy[slot] = 1'b0;
      end
      slot_gen[slot] = slot_gen[slot] + 32'd1;
      if (slot_gen[slot] == 0) slot_gen[slot] = 32'd1;
      slot_begin_pos[slot] = head_pos;
      slot_fence[slot] = head_pos;
      slot_open[slot] = 1'b1;
      open_slot = slot[3:0];
      open_valid = 1'b1;
      open_wraps = '0;
      return ST_OK;
   endfunction

   // Grants a slice to the open frame; the slice fields are filled only on success.
   function automatic logic [3:0] grant_slice(input logic [31:0] size, input logic [31:0] algn,
                                              inout rsp_type r);
      logic [63:0] cap, room, phys, rem, aligned, pad, used;
      logic        wrapped;
      cap = {32'd0, ring_cap};
      wrapped = 1'b0;
      if (!open_valid) return ST_NO_FRAME;
      if (size == 0 || algn == 0) return ST_INVALID;
      if ({32'd0, size} > cap) return ST_NO_SPACE;
      room = cap - (head_pos - tail_pos);
      phys = head_pos % cap;
      rem = phys % {32'd0, algn};
      aligned = (rem == 0) ? phys : phys + {32'd0, algn} - rem;
      if (aligned > 64'hFFFF_FFFF) return ST_OVERFLOW;
      pad = aligned - phys;
      if (aligned + {32'd0, size} > cap) begin
         pad = cap - phys;
         aligned = '0;
         wrapped = 1'b1;
      end
      used = pad + {32'd0, size};
      if (head_pos > ~used) return ST_OVERFLOW;
      if (used > room) return ST_NO_SPACE;
      r.slice_offset = aligned[31:0];
      r.slice_virtual = head_pos + pad;
      r.slice_frame = open_slot[2:0];
      r.slice_generation = slot_gen[open_slot];
      head_pos = head_pos + used;
      if (wrapped) begin
         wrap_cnt = bump(wrap_cnt);
         open_wraps = bump(open_wraps);
      end
      return ST_OK;
   endfunction

   function automatic rsp_type predict_result(input req_type q);
      rsp_type     r;
      logic [31:0] occ, cap;
      logic [3:0]  n;
      r = '0;
      if (q.func > FUNC_RETIRE) begin
         r.status = ST_INVALID;
      end else if (!ring_ready()) begin
         r.status = ST_NOT_INIT;
         if (q.func == FUNC_ALLOC) fail_cnt = bump(fail_cnt);
      end else if (q.func == FUNC_BEGIN) begin
         r.status = begin_frame(q.frame_slot, q.waited);
      end else if (q.func == FUNC_ALLOC) begin
         r.status = grant_slice(q.request_size, q.align_bytes, r);
         if (r.status != ST_OK) fail_cnt = bump(fail_cnt);
      end else if (!open_valid) begin
         r.status = (q.func == FUNC_RETIRE) ? ST_OK : ST_NO_FRAME;
         if (q.func == FUNC_RETIRE) begin
            for (int i = 0; i < ring_frames; i++) slot_busy[i] = 1'b0;
            tail_pos = head_pos;
         end
      end else if (q.func == FUNC_RETIRE) begin
         r.status = ST_ACTIVE;
      end else begin
         r.status = ST_OK;
         slot_open[open_slot] = 1'b0;
         if (q.func == FUNC_END) begin
            slot_fence[open_slot] = head_pos;
            slot_busy[open_slot] = 1'b1;
         end else begin
            head_pos = slot_begin_pos[open_slot];
            if (wrap_cnt != 32'hFFFF_FFFF)
               wrap_cnt = (wrap_cnt >= open_wraps) ? wrap_cnt - open_wraps : 32'd0;
         end
         open_wraps = '0;
         open_valid = 1'b0;
      end
      cap = ring_ready() ? ring_cap : 32'd0;
      occ = head_pos[31:0] - tail_pos[31:0];
      n = '0;
      if (ring_ready())
         for (int i = 0; i < ring_frames; i++) if (slot_busy[i]) n = n + 4'd1;
      r.used_bytes = occ;
      r.free_bytes = cap - occ;
      r.in_flight_frames = n;
      r.frame_open = open_valid;
      r.wraps_total = wrap_cnt;
      r.stalls_total = stall_cnt;
      r.failures_total = fail_cnt;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
      end
   endfunction

   function automatic void compare_result(input rsp_type w, input rsp_type g);
      check_field("status", w.status, g.status);
      check_field("slice_offset", w.slice_offset, g.slice_offset);
      check_field("slice_virtual", w.slice_virtual, g.slice_virtual);
      check_field("slice_frame", w.slice_frame, g.slice_frame);
      check_field("slice_generation", w.slice_generation, g.slice_generation);
      check_field("used_bytes", w.used_bytes, g.used_bytes);
      check_field("free_bytes", w.free_bytes, g.free_bytes);
      check_field("in_flight_frames", w.in_flight_frames, g.in_flight_frames);
      check_field("frame_open", w.frame_open, g.frame_open);
      check_field("wraps_total", w.wraps_total, g.wraps_total);
      check_field("stalls_total", w.stalls_total, g.stalls_total);
      check_field("failures_total", w.failures_total, g.failures_total);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         errors = 0;
         ring_on = 1'b0;
         ring_cap = CAPACITY_RESET;
         ring_frames = FRAMES_RESET;
         clear_ring();
         pending_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_rsp.size() == 0) begin
               errors++;
               if (errors <= 10) $display("%0t: result item with none expected", $realtime);
            end else begin
               compare_result(pending_rsp.pop_front(), rsp_data);
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_ENABLE:   ring_on = csr_wdata[0];
               REG_CAPACITY: ring_cap = csr_wdata;
               REG_FRAMES:   ring_frames = csr_wdata[3:0];
               default: ;
            endcase
            if ((csr_index == REG_ENABLE) || (csr_index == REG_CAPACITY) ||
                (csr_index == REG_FRAMES))
               clear_ring();
         end
         if (start && !busy) pending_rsp.push_back(predict_result(req_data));
      end
      outstanding <= pending_rsp.size();
   end

endmodule

// ===== verif/frame_fenced_ring_allocator_tb.sv =====
// Testbench top for the frame-fenced ring allocator: clock, reset, stimulus and verdict.
// Depends on ffra_pkg, the allocator RTL and frame_fenced_ring_allocator_chk.
module frame_fenced_ring_allocator_tb;
   import ffra_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_ENABLE;
   logic [31:0] csr_wdata = '0;
   int          errors, outstanding;

   // Copy of the current settings, used only to shape the stimulus.
   logic [31:0] cur_cap = CAPACITY_RESET;
   logic [3:0]  cur_frames = FRAMES_RESET;
   int          idle_pct = 0;
   int          idle_cnt = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   frame_fenced_ring_allocator uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   frame_fenced_ring_allocator_chk checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .outstanding(outstanding)
   );

   // The watchdog restarts whenever an item goes in or a result comes out; the
   // slowest item is an allocation.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cnt <= 0;
      end else if (idle_cnt >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cnt <= idle_cnt + 1;
      end
   end

   // Presents one item and returns right after the edge that accepts it. Busy is
   // registered, so looking at it on the falling edge tells whether the next
   // rising edge takes the item. A random gap may follow, per the idle setting.
   task automatic issue(input req_type item);
      start <= 1'b1;
      req_data <= item;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic cmd(input logic [2:0] f, input logic [7:0] slot, input logic w,
                      input logic [31:0] size, input logic [31:0] algn);
      req_type item;
      item.func = f;
      item.frame_slot = slot;
      item.waited = w;
      item.request_size = size;
      item.align_bytes = algn;
      issue(item);
   endtask

   // Registers are only written once the block is idle and every result is in.
   task automatic write_setup(input logic en, input logic [31:0] cap, input logic [3:0] fr);
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (6) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= REG_FRAMES;
      csr_wdata <= {28'd0, fr};
      @(posedge clock);
      csr_index <= REG_CAPACITY;
      csr_wdata <= cap;
      @(posedge clock);
      csr_index <= REG_ENABLE;
      csr_wdata <= {31'd0, en};
      @(posedge clock);
      csr_we <= 1'b0;
      cur_cap = cap;
      cur_frames = fr;
   endtask

   task automatic random_alloc();
      logic [31:0] size, algn;
      case ($urandom_range(0, 9))
         0: size = $urandom;
         1: size = cur_cap;
         default: size = $urandom_range(1, cur_cap / 8 + 1);
      endcase
      case ($urandom_range(0, 9))
         0: algn = $urandom;
         1, 2: algn = $urandom_range(1, cur_cap);
         default: algn = 32'd1 << $urandom_range(0, 10);
      endcase
      cmd(FUNC_ALLOC, '0, $urandom_range(0, 1), size, algn);
   endtask

   // Mostly well-formed frames (begin, a few allocations, end or abort) with
   // random content, plus some broken sequences and fully random items.
   task automatic random_run(input int count);
      int          stop;
      logic [7:0]  slot;
      stop = count;
      while (stop > 0) begin
         if ($urandom_range(0, 99) < 10) begin
            cmd($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom);
            stop--;
         end else begin
            if (cur_frames != 0 && $urandom_range(0, 9) != 0)
               slot = $urandom_range(0, cur_frames - 1);
            else
               slot = $urandom_range(0, 255);
            cmd(FUNC_BEGIN, slot, $urandom_range(0, 1), $urandom, $urandom);
            stop--;
            repeat ($urandom_range(0, 6)) begin
               random_alloc();
               stop--;
            end
            case ($urandom_range(0, 19))
               0: ;
               1, 2, 3, 4: cmd(FUNC_ABORT, $urandom, $urandom, $urandom, $urandom);
               default: cmd(FUNC_END, $urandom, $urandom, $urandom, $urandom);
            endcase
            stop--;
            if ($urandom_range(0, 11) == 0) begin
               cmd(FUNC_RETIRE, $urandom, $urandom, $urandom, $urandom);
               stop--;
            end
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset the ring is not enabled: all but the invalid function code report not ready.
      cmd(FUNC_BEGIN, 8'hFF, 1'b1, '1, '1);
      cmd(FUNC_ALLOC, 8'h00, 1'b0, 32'd1, 32'd1);
      cmd(FUNC_RETIRE, '0, '0, '0, '0);
      cmd(3'd7, '1, 1'b1, '1, '1);

      write_setup(1'b1, 32'd256, 4'd3);
      cmd(FUNC_END, '0, '0, '0, '0);
      cmd(FUNC_ALLOC, '0, '0, 32'd4, 32'd4);
      cmd(FUNC_RETIRE, '0, '0, '0, '0);
      cmd(FUNC_BEGIN, 8'd3, '0, '0, '0);
      cmd(FUNC_BEGIN, 8'd0, '0, '0, '0);
      cmd(FUNC_BEGIN, 8'd1, '0, '0, '0);
      cmd(FUNC_ALLOC, '0, '0, 32'd0, 32'd8);
      cmd(FUNC_ALLOC, '0, '0, 32'd8, 32'd0);
      cmd(FUNC_ALLOC, '0, '0, 32'd257, 32'd1);
      cmd(FUNC_ALLOC, '0, '0, 32'd100, 32'd1);
      cmd(FUNC_ALLOC, '0, '0, 32'd100, 32'd64);
      cmd(FUNC_RETIRE, '0, '0, '0, '0);
      cmd(FUNC_END, '0, '0, '0, '0);
      cmd(FUNC_BEGIN, 8'd1, '0, '0, '0);
      cmd(FUNC_ALLOC, '0, '0, 32'd60, 32'd16);
      cmd(FUNC_END, '0, '0, '0, '0);
      // Slots zero and one were ended at the same head position, so reopening slot one is in order.
      cmd(FUNC_BEGIN, 8'd1, 1'b1, '0, '0);
      cmd(FUNC_BEGIN, 8'd0, 1'b1, '0, '0);
      cmd(FUNC_ALLOC, '0, '0, 32'd120, 32'd32);
      cmd(FUNC_ABORT, '0, '0, '0, '0);
      cmd(3'd5, '0, '0, '0, '0);
      cmd(3'd6, '0, '0, '0, '0);

      // Largest ring: an aligned offset past 32 bits reports overflow.
      write_setup(1'b1, 32'hFFFF_FFFF, 4'd8);
      cmd(FUNC_BEGIN, 8'd7, '0, '0, '0);
      cmd(FUNC_ALLOC, '0, '0, 32'h8000_0001, 32'd1);
      cmd(FUNC_ALLOC, '0, '0, 32'd1, 32'h8000_0000);
      cmd(FUNC_ALLOC, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      cmd(FUNC_END, '0, '0, '0, '0);
      random_run(250);

      idle_pct = 72;
      write_setup(1'b1, 32'd4096, 4'd3);
      random_run(300);

      idle_pct = 11;
      write_setup(1'b1, 32'd1, 4'd1);
      random_run(150);

      idle_pct = 0;
      write_setup(1'b1, 32'd777, 4'd8);
      random_run(250);

      // Settings that leave the ring not ready.
      idle_pct = 72;
      write_setup(1'b1, 32'd1000, 4'd15);
      random_run(40);
      write_setup(1'b1, 32'd1000, 4'd0);
      random_run(20);
      write_setup(1'b1, 32'd0, 4'd2);
      random_run(20);
      write_setup(1'b0, 32'd512, 4'd2);
      random_run(20);

      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (150) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
